// File: sv/tpot_pkg.sv
// ----------------------------------------------------------------------------
// tpot_pkg
// shared widths and types for the triangle pair overlap test
// ----------------------------------------------------------------------------
package tpot_pkg;

  localparam int unsigned CoordWidth = 16;
  localparam int unsigned WordWidth  = 48;
  localparam int unsigned DiffWidth  = CoordWidth + 1;
  localparam int unsigned NormWidth  = 2 * DiffWidth + 2;
  localparam int unsigned DotWidth   = 2 * DiffWidth + 1;
  localparam int unsigned FaceWidth  = DiffWidth + NormWidth + 3;
  localparam int unsigned EdgeWidth  = 2 * DotWidth + 2;
  localparam int unsigned QueueDepth = 2;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef coord_t [2:0] vec_t;
  typedef vec_t [2:0] tri_t;

  typedef struct packed {
    tri_t tri_a;
    tri_t tri_b;
  } pair_t;

  function automatic vec_t unpack_vertex(input logic [WordWidth-1:0] w);
    logic [3*CoordWidth-1:0] ext;
    vec_t v;
    ext = '0;
    for (int k = 0; k < 3; k++) begin
      if (k * CoordWidth < WordWidth) begin
        for (int b = 0; b < CoordWidth; b++) begin
          if (k * CoordWidth + b < WordWidth) begin
            ext[k*CoordWidth+b] = w[k*CoordWidth+b];
          end
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      v[k] = ext[k*CoordWidth +: CoordWidth];
    end
    return v;
  endfunction

endpackage

// File: sv/triangle_pair_overlap_test_core.sv
// ----------------------------------------------------------------------------
// triangle_pair_overlap_test_core
// exact integer triangle/triangle overlap test, both directions
// ----------------------------------------------------------------------------
//   channel  | handshake        | words
//   input    | push / full      | six packed vertices (x,y,z signed)
//   result   | pop / empty      | overlap_o
//
// one word per cycle sustained while results are popped; an accepted word
// reaches the result queue through the input queue and four pipeline stages
// throughput is set by the fully pipelined multiplier stages
// a stalled result queue backs up into the pipeline credit and then the
// input queue, so full rises only after both are used up
// asynchronous active-low reset empties both queues and the pipeline
module triangle_pair_overlap_test_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [tpot_pkg::WordWidth-1:0] tri_a_vertex0_i,
  input  logic [tpot_pkg::WordWidth-1:0] tri_a_vertex1_i,
  input  logic [tpot_pkg::WordWidth-1:0] tri_a_vertex2_i,
  input  logic [tpot_pkg::WordWidth-1:0] tri_b_vertex0_i,
  input  logic [tpot_pkg::WordWidth-1:0] tri_b_vertex1_i,
  input  logic [tpot_pkg::WordWidth-1:0] tri_b_vertex2_i,
  output logic                           empty,
  input  logic                           pop,
  output logic                           overlap_o
);
  import tpot_pkg::*;

  // front to back queue handshake
  logic  fb_valid, fb_ready;
  pair_t fb_pair;

  tpot_front u_front (
    .clk_i, .rst_ni,
    .push_i (push),
    .full_o (full),
    .tri_a_vertex0_i, .tri_a_vertex1_i, .tri_a_vertex2_i,
    .tri_b_vertex0_i, .tri_b_vertex1_i, .tri_b_vertex2_i,
    .valid_o (fb_valid),
    .ready_i (fb_ready),
    .pair_o  (fb_pair)
  );

  // back end: pipelined plane tests and result queue
  tpot_back u_back (
    .clk_i, .rst_ni,
    .valid_i (fb_valid),
    .ready_o (fb_ready),
    .pair_i  (fb_pair),
    .empty_o (empty),
    .pop_i   (pop),
    .overlap_o
  );

endmodule

// File: sv/tpot_front.sv
// ----------------------------------------------------------------------------
// tpot_front
// input side: unpacks vertex words and pushes triangle pairs into a queue
// ----------------------------------------------------------------------------
module tpot_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  output logic                             full_o,
  input  logic [tpot_pkg::WordWidth-1:0]   tri_a_vertex0_i,
  input  logic [tpot_pkg::WordWidth-1:0]   tri_a_vertex1_i,
  input  logic [tpot_pkg::WordWidth-1:0]   tri_a_vertex2_i,
  input  logic [tpot_pkg::WordWidth-1:0]   tri_b_vertex0_i,
  input  logic [tpot_pkg::WordWidth-1:0]   tri_b_vertex1_i,
  input  logic [tpot_pkg::WordWidth-1:0]   tri_b_vertex2_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output tpot_pkg::pair_t                  pair_o
);
  import tpot_pkg::*;

  pair_t              mem_q [QueueDepth];
  logic               wptr_q, rptr_q;
  logic [1:0]         cnt_q, cnt_d;
  pair_t              in_pair;
  logic               do_push, do_pop;

  always_comb begin
    in_pair.tri_a[0] = unpack_vertex(tri_a_vertex0_i);
    in_pair.tri_a[1] = unpack_vertex(tri_a_vertex1_i);
    in_pair.tri_a[2] = unpack_vertex(tri_a_vertex2_i);
    in_pair.tri_b[0] = unpack_vertex(tri_b_vertex0_i);
    in_pair.tri_b[1] = unpack_vertex(tri_b_vertex1_i);
    in_pair.tri_b[2] = unpack_vertex(tri_b_vertex2_i);
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign pair_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = valid_o && ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 2'd1;
    if (!do_push && do_pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= in_pair;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: sv/tpot_back.sv
// ----------------------------------------------------------------------------
// tpot_back
// four-stage pipeline for both plane tests, with an output queue
// ----------------------------------------------------------------------------
module tpot_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  tpot_pkg::pair_t pair_i,
  output logic            empty_o,
  input  logic            pop_i,
  output logic            overlap_o
);
  import tpot_pkg::*;

  typedef logic signed [DiffWidth-1:0] diff_t;
  typedef logic signed [NormWidth-1:0] norm_t;
  typedef logic signed [DotWidth-1:0]  dot_t;
  typedef logic signed [FaceWidth-1:0] face_t;
  typedef logic signed [EdgeWidth-1:0] edge_t;
  typedef diff_t [2:0] dvec_t;

  // stage 1: edge vectors, face normals, vertex offsets (per direction)
  // stage 2: face distances, edge dots
  // stage 3: edge distances and flags
  logic [3:0]      vld_q;
  logic            adv;
  dvec_t           a1_q [2], b1_q [2];
  norm_t           n1_q [2][3];
  dvec_t           d1_q [2][3][3];   // [dir][edge i][vertex j] = Uj - Ti
  dvec_t           e1_q [2][3];
  face_t           f2_q [2][3];
  dot_t            da2_q [2][3][3], db2_q [2][3][3], ea2_q [2][3], eb2_q [2][3];
  logic            face_ok3_q [2];
  logic            edge_out3_q [2][3];
  logic            res_q;

  // output queue of depth 8 covers the four stages plus the pop turnaround
  logic            oq_q [8];
  logic [2:0]      owp_q, orp_q;
  logic [3:0]      ocnt_q, ocnt_d;
  logic [2:0]      inflight;
  logic            opush, opop;

  assign inflight = 3'(vld_q[0]) + 3'(vld_q[1]) + 3'(vld_q[2]);
  assign adv      = 1'b1;
  assign ready_o  = (ocnt_q + 4'(inflight) + 4'(vld_q[3])) < 4'd8;
  assign opush    = vld_q[3];
  assign opop     = pop_i && !empty_o;
  assign empty_o  = (ocnt_q == 4'd0);
  assign overlap_o = oq_q[orp_q];

  function automatic diff_t sub_c(input coord_t x, input coord_t y);
    return diff_t'(x) - diff_t'(y);
  endfunction

  function automatic dot_t vdot(input dvec_t x, input dvec_t y);
    logic signed [2*DiffWidth-1:0] p0, p1, p2;
    p0 = x[0] * y[0];
    p1 = x[1] * y[1];
    p2 = x[2] * y[2];
    return dot_t'(p0) + dot_t'(p1) + dot_t'(p2);
  endfunction

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 2; r++) begin
      tri_t t, u;
      dvec_t a, b;
      logic signed [2*DiffWidth-1:0] m0, m1;
      t = (r == 0) ? pair_i.tri_a : pair_i.tri_b;
      u = (r == 0) ? pair_i.tri_b : pair_i.tri_a;
      for (int k = 0; k < 3; k++) begin
        a[k] = sub_c(t[1][k], t[0][k]);
        b[k] = sub_c(t[2][k], t[0][k]);
      end
      a1_q[r] <= a;
      b1_q[r] <= b;
      for (int k = 0; k < 3; k++) begin
        m0 = a[(k+1)%3] * b[(k+2)%3];
        m1 = a[(k+2)%3] * b[(k+1)%3];
        n1_q[r][k] <= norm_t'(m0) - norm_t'(m1);
      end
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          e1_q[r][i][k] <= sub_c(t[(i+1)%3][k], t[i][k]);
        end
        for (int j = 0; j < 3; j++) begin
          for (int k = 0; k < 3; k++) begin
            d1_q[r][i][j][k] <= sub_c(u[j][k], t[i][k]);
          end
        end
      end
    end
    for (int r = 0; r < 2; r++) begin
      for (int j = 0; j < 3; j++) begin
        logic signed [DiffWidth+NormWidth-1:0] q0, q1, q2;
        q0 = d1_q[r][0][j][0] * n1_q[r][0];
        q1 = d1_q[r][0][j][1] * n1_q[r][1];
        q2 = d1_q[r][0][j][2] * n1_q[r][2];
        f2_q[r][j] <= face_t'(q0) + face_t'(q1) + face_t'(q2);
      end
      for (int i = 0; i < 3; i++) begin
        ea2_q[r][i] <= vdot(e1_q[r][i], a1_q[r]);
        eb2_q[r][i] <= vdot(e1_q[r][i], b1_q[r]);
        for (int j = 0; j < 3; j++) begin
          da2_q[r][i][j] <= vdot(d1_q[r][i][j], a1_q[r]);
          db2_q[r][i][j] <= vdot(d1_q[r][i][j], b1_q[r]);
        end
      end
    end
    for (int r = 0; r < 2; r++) begin
      logic pos, neg, all_out;
      logic signed [2*DotWidth-1:0] p0, p1;
      edge_t s;
      pos = 1'b0;
      neg = 1'b0;
      for (int j = 0; j < 3; j++) begin
        if (f2_q[r][j] > 0) pos = 1'b1;
        if (f2_q[r][j] < 0) neg = 1'b1;
      end
      face_ok3_q[r] <= pos && neg;
      for (int i = 0; i < 3; i++) begin
        all_out = 1'b1;
        for (int j = 0; j < 3; j++) begin
          p0 = da2_q[r][i][j] * eb2_q[r][i];
          p1 = db2_q[r][i][j] * ea2_q[r][i];
          s  = edge_t'(p0) - edge_t'(p1);
          if (s <= 0) all_out = 1'b0;
        end
        edge_out3_q[r][i] <= all_out;
      end
    end
    res_q <= face_ok3_q[0] && face_ok3_q[1]
          && !edge_out3_q[0][0] && !edge_out3_q[0][1] && !edge_out3_q[0][2]
          && !edge_out3_q[1][0] && !edge_out3_q[1][1] && !edge_out3_q[1][2];
    if (opush) oq_q[owp_q] <= res_q;
  end

  always_comb begin
    ocnt_d = ocnt_q;
    if (opush && !opop) ocnt_d = ocnt_q + 4'd1;
    if (!opush && opop) ocnt_d = ocnt_q - 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      owp_q  <= '0;
      orp_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (adv) vld_q <= {vld_q[2:0], valid_i && ready_o};
      if (opush) owp_q <= owp_q + 3'd1;
      if (opop)  orp_q <= orp_q + 3'd1;
      ocnt_q <= ocnt_d;
    end
  end

endmodule

// File: sv/tpot_checker.sv
// ----------------------------------------------------------------------------
// tpot_checker
// port-level checks for the overlap test core
// ----------------------------------------------------------------------------
module tpot_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input logic overlap_o
);

  // both queues are empty right after reset
  a_empty_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (empty && !full))
    else $error("queues not empty after reset");

  // no result appears sooner than the pipeline allows
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty && $past(empty) && !$past(push, 1) && !$past(push, 2)
     && !$past(push, 3) && !$past(push, 4) && !$past(push, 5)
     && $past(rst_ni, 5)) |=> empty)
    else $error("result without an accepted word");

  // a waiting result holds until popped
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(overlap_o)))
    else $error("waiting result changed");

endmodule

bind triangle_pair_overlap_test_core tpot_checker u_tpot_checker (
  .clk_i, .rst_ni, .push, .full, .empty, .pop, .overlap_o
);
